// ----- rtl/gate_light_relay_controller_assert.svh -----
// assertion macros for the gate and light relay controller
`ifndef GATE_LIGHT_RELAY_CONTROLLER_ASSERT_SVH
`define GATE_LIGHT_RELAY_CONTROLLER_ASSERT_SVH

// condition holds at every edge out of reset
`define GLRC_ASSERT_ALWAYS(lbl, cond) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond)) \
    else $error("glrc: invariant violated");

// antecedent at one edge implies consequent at the next
`define GLRC_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("glrc: next-cycle check failed");

`endif

// ----- rtl/glrc_pkg.sv -----
`timescale 1ns / 1ps
package glrc_pkg;

  localparam int NUM_RELAYS = 4;
  localparam int CFG_W      = 16;

  typedef enum logic [2:0] {
    MODE_TICK         = 3'd0,
    MODE_GATE_PRESS   = 3'd1,
    MODE_LIGHT_PRESS  = 3'd2,
    MODE_SWITCH       = 3'd3,
    MODE_REMOTE_LIGHT = 3'd4,
    MODE_REMOTE_BYP   = 3'd5
  } mode_t;

  typedef enum logic [2:0] {
    GS_UNKNOWN = 3'd0,
    GS_ERROR   = 3'd1,
    GS_OPEN    = 3'd2,
    GS_CLOSED  = 3'd3,
    GS_STOPPED = 3'd4,
    GS_OPENING = 3'd5,
    GS_CLOSING = 3'd6
  } gate_st_t;

  localparam logic [1:0] CH_BYPASS = 2'd0;
  localparam logic [1:0] CH_STOP   = 2'd1;
  localparam logic [1:0] CH_GATE   = 2'd2;
  localparam logic [1:0] CH_LIGHT  = 2'd3;

  localparam logic CFG_GATE_PULSE   = 1'b0;
  localparam logic CFG_BYPASS_PULSE = 1'b1;

  localparam logic [CFG_W-1:0] GATE_PULSE_RST   = 16'd10;
  localparam logic [CFG_W-1:0] BYPASS_PULSE_RST = 16'd300;

endpackage

// ----- rtl/gate_light_relay_controller.sv -----
`timescale 1ns / 1ps
// channel   dir  handshake             payload
// in_       in   in_tvalid/in_tready   tuser: mode; tdata: down, up, remote value
// out_      out  out_tvalid/out_tready tdata: gate status, light, relay levels
// cfg_      in   cfg_we                cfg_addr selects pulse length register
//
// one request per cycle sustained while the output is not stalled; a taken request
// is held in the input stage, then enters the result register and can leave on the output
// all state updates in one shallow pass between the two registers
// rst_n is synchronous, active low; pulse lengths return to 10 and 300 ticks
// a stalled output holds the input stage; in_tready drops only when both are full
`include "gate_light_relay_controller_assert.svh"
module gate_light_relay_controller
  import glrc_pkg::*;
#(
  parameter int TIMER_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [7:0]       in_tdata,   // [0] down_switch, [1] up_switch, [2] remote_value
  input  logic [2:0]       in_tuser,   // [2:0] mode
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [7:0]       out_tdata,  // [2:0] gate_status, [3] light_on, [7:4] relay_levels
  input  logic             cfg_we,
  input  logic             cfg_addr,
  input  logic [CFG_W-1:0] cfg_wdata
);

  localparam int LD_W = (TIMER_BITS > CFG_W) ? TIMER_BITS : CFG_W;
  localparam logic [LD_W-1:0] TIMER_MAX = LD_W'((65'd1 << TIMER_BITS) - 65'd1);

  logic                  s1_valid_r;
  logic [2:0]            s1_mode_r;
  logic                  s1_down_r, s1_up_r, s1_rv_r;
  logic                  out_valid_r;
  logic [7:0]            out_data_r;

  logic [CFG_W-1:0]      gate_pulse_r, bypass_pulse_r;
  gate_st_t              gate_st_r, gate_st_nxt;
  logic                  light_r, light_nxt;
  logic                  bypass_r, bypass_nxt;
  logic [NUM_RELAYS-1:0] relay_r, relay_nxt;
  logic [TIMER_BITS-1:0] timer_r   [NUM_RELAYS];
  logic [TIMER_BITS-1:0] timer_nxt [NUM_RELAYS];
  logic [NUM_RELAYS-1:0] on_req, off_req;
  logic                  adv;

  function automatic logic [TIMER_BITS-1:0] load_val(input logic [CFG_W-1:0] ticks);
    logic [LD_W-1:0] t;
    t = LD_W'(ticks);
    if (t > TIMER_MAX) t = TIMER_MAX;
    return t[TIMER_BITS-1:0];
  endfunction

  assign adv        = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || adv;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  always_comb begin
    gate_st_nxt = gate_st_r;
    light_nxt   = light_r;
    bypass_nxt  = bypass_r;
    on_req      = '0;
    off_req     = '0;
    for (int i = 0; i < NUM_RELAYS; i++) begin
      timer_nxt[i] = timer_r[i];
    end
    case (s1_mode_r)
      MODE_TICK: begin
        for (int i = 0; i < NUM_RELAYS; i++) begin
          if (timer_r[i] != '0) begin
            timer_nxt[i] = timer_r[i] - TIMER_BITS'(1);
            if (timer_r[i] == TIMER_BITS'(1)) off_req[i] = 1'b1;
          end
        end
      end
      MODE_GATE_PRESS: begin
        on_req[CH_GATE]    = 1'b1;
        timer_nxt[CH_GATE] = load_val(gate_pulse_r);
        if (!bypass_r) begin
          on_req[CH_BYPASS]    = 1'b1;
          timer_nxt[CH_BYPASS] = load_val(bypass_pulse_r);
        end
        case (gate_st_r)
          GS_OPENING: gate_st_nxt = GS_STOPPED;
          GS_STOPPED: gate_st_nxt = GS_CLOSING;
          GS_CLOSING: gate_st_nxt = GS_OPENING;
          default:    gate_st_nxt = gate_st_r;
        endcase
      end
      MODE_LIGHT_PRESS: begin
        light_nxt         = !light_r;
        on_req[CH_LIGHT]  = !light_r;
        off_req[CH_LIGHT] = light_r;
      end
      MODE_SWITCH: begin
        if (s1_down_r && s1_up_r) begin
          gate_st_nxt = GS_ERROR;
        end else if (!s1_down_r && !s1_up_r) begin
          if (gate_st_r == GS_CLOSED) begin
            light_nxt        = 1'b1;
            on_req[CH_LIGHT] = 1'b1;
            gate_st_nxt      = GS_OPENING;
          end else if (gate_st_r == GS_OPEN) begin
            light_nxt         = 1'b0;
            off_req[CH_LIGHT] = 1'b1;
            gate_st_nxt       = GS_CLOSING;
          end
        end else if (s1_up_r) begin
          light_nxt        = 1'b1;
          on_req[CH_LIGHT] = 1'b1;
          gate_st_nxt      = GS_OPEN;
        end else begin
          light_nxt         = 1'b0;
          off_req[CH_LIGHT] = 1'b1;
          gate_st_nxt       = GS_CLOSED;
        end
      end
      MODE_REMOTE_LIGHT: begin
        light_nxt         = s1_rv_r;
        on_req[CH_LIGHT]  = s1_rv_r;
        off_req[CH_LIGHT] = !s1_rv_r;
      end
      MODE_REMOTE_BYP: begin
        bypass_nxt         = s1_rv_r;
        on_req[CH_BYPASS]  = s1_rv_r;
        off_req[CH_BYPASS] = !s1_rv_r;
      end
      default: ;
    endcase
    relay_nxt = (relay_r | on_req) & ~off_req;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r     <= 1'b0;
      out_valid_r    <= 1'b0;
      gate_pulse_r   <= GATE_PULSE_RST;
      bypass_pulse_r <= BYPASS_PULSE_RST;
      gate_st_r      <= GS_UNKNOWN;
      light_r        <= 1'b0;
      bypass_r       <= 1'b0;
      relay_r        <= '0;
      for (int i = 0; i < NUM_RELAYS; i++) begin
        timer_r[i] <= '0;
      end
    end else begin
      if (cfg_we) begin
        if (cfg_addr == CFG_GATE_PULSE) gate_pulse_r <= cfg_wdata;
        else bypass_pulse_r <= cfg_wdata;
      end
      if (in_tready) s1_valid_r <= in_tvalid;
      if (adv) begin
        out_valid_r <= 1'b1;
        gate_st_r   <= gate_st_nxt;
        light_r     <= light_nxt;
        bypass_r    <= bypass_nxt;
        relay_r     <= relay_nxt;
        for (int i = 0; i < NUM_RELAYS; i++) begin
          timer_r[i] <= timer_nxt[i];
        end
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_tvalid && in_tready) begin
      s1_mode_r <= in_tuser;
      s1_down_r <= in_tdata[0];
      s1_up_r   <= in_tdata[1];
      s1_rv_r   <= in_tdata[2];
    end
    if (adv) begin
      out_data_r <= {relay_nxt, light_nxt, gate_st_nxt};
    end
  end

  // stop relay and its timer are never driven
  `GLRC_ASSERT_ALWAYS(a_stop_idle, relay_r[CH_STOP] == 1'b0 && timer_r[CH_STOP] == '0)
  // light relay tracks the light flag
  `GLRC_ASSERT_ALWAYS(a_light_sync, relay_r[CH_LIGHT] == light_r)
  // a gate press with bypass off pulls in the bypass relay
  `GLRC_ASSERT_NEXT(a_byp_pulse, adv && s1_mode_r == MODE_GATE_PRESS && !bypass_r,
                    relay_r[CH_BYPASS] && relay_r[CH_GATE])

endmodule
